FILE: hw/rtl/bps_pkg.sv
// Shared types and constants for the byte plane split block.
// No dependencies; every other file imports this package.
package bps_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int MAX_WIDTH    = 16;
	localparam int RESET_WIDTH  = 4;

	localparam int CFG_W   = 5;
	localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W  = $clog2(BUFFER_BYTES);
	localparam int BIE_W   = $clog2(MAX_WIDTH);
	localparam int PLANE_W = $clog2(MAX_WIDTH + 1);
	localparam int RA_W    = $clog2(BUFFER_BYTES * MAX_WIDTH + 1);

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       final_load;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       status;
		logic       overflowed;
	} out_t;

	// One queued operation for the back end: a store write or a result read.
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              last;
		logic              status;
		logic              ovf;
		logic              zero;
	} op_entry_t;

endpackage

FILE: hw/rtl/bps_front.sv
// Front end: accepts items, keeps the load and read counters, and turns
// each item into a store write or a read request. Depends on bps_pkg.
module bps_front import bps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  in_t              req,
	input  logic             accept,
	output op_entry_t        q_entry,
	output logic             q_push
);

	logic [CFG_W-1:0]   width_q;
	logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
	logic [BIE_W-1:0]   bie_q, bie_d;
	logic [CNT_W-1:0]   elem_cnt_q, elem_cnt_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	logic [CNT_W-1:0]   elem_idx_q, elem_idx_d;
	logic [RA_W-1:0]    raddr_q, raddr_d;
	logic               complete_q, complete_d;
	logic               ovf_q, ovf_d;
	logic [PLANE_W-1:0] w;

	function automatic logic [PLANE_W-1:0] eff_width(input logic [CFG_W-1:0] v);
		logic [PLANE_W-1:0] r;
		if (v == '0) begin
			r = PLANE_W'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			r = PLANE_W'(MAX_WIDTH);
		end else begin
			r = PLANE_W'(v);
		end
		return r;
	endfunction

	assign w = eff_width(width_q);

	always_comb begin
		load_cnt_d = load_cnt_q;
		bie_d      = bie_q;
		elem_cnt_d = elem_cnt_q;
		plane_d    = plane_q;
		elem_idx_d = elem_idx_q;
		raddr_d    = raddr_q;
		complete_d = complete_q;
		ovf_d      = ovf_q;
		q_push     = 1'b0;
		q_entry    = '0;
		q_entry.op = OP_WRITE;
		if (accept) begin
			if (req.command == CMD_LOAD) begin
				// A load after a finished buffer opens a new one.
				if (complete_q) begin
					load_cnt_d = '0;
					bie_d      = '0;
					elem_cnt_d = '0;
					plane_d    = '0;
					elem_idx_d = '0;
					raddr_d    = '0;
					complete_d = 1'b0;
				end
				if (32'(load_cnt_d) < BUFFER_BYTES) begin
					q_push       = 1'b1;
					q_entry.op   = OP_WRITE;
					q_entry.addr = load_cnt_d[ADDR_W-1:0];
					q_entry.data = req.data_byte;
					load_cnt_d   = load_cnt_d + CNT_W'(1);
					if (PLANE_W'(bie_d) + PLANE_W'(1) >= w) begin
						bie_d      = '0;
						elem_cnt_d = elem_cnt_d + CNT_W'(1);
					end else begin
						bie_d = bie_d + BIE_W'(1);
					end
				end else begin
					ovf_d = 1'b1;
				end
				if (req.final_load) begin
					complete_d = 1'b1;
					plane_d    = '0;
					elem_idx_d = '0;
					raddr_d    = '0;
				end
			end else begin
				q_push         = 1'b1;
				q_entry.op     = OP_READ;
				q_entry.status = 1'b1;
				q_entry.zero   = 1'b1;
				q_entry.ovf    = ovf_q;
				if (complete_q && elem_cnt_q != '0 && plane_q < w) begin
					q_entry.status = 1'b0;
					q_entry.zero   = (32'(raddr_q) >= BUFFER_BYTES);
					q_entry.addr   = raddr_q[ADDR_W-1:0];
					if (elem_idx_q + CNT_W'(1) >= elem_cnt_q) begin
						q_entry.last = (plane_q + PLANE_W'(1) >= w);
						plane_d      = plane_q + PLANE_W'(1);
						elem_idx_d   = '0;
						raddr_d      = RA_W'(plane_d);
					end else begin
						elem_idx_d = elem_idx_q + CNT_W'(1);
						raddr_d    = raddr_q + RA_W'(w);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= CFG_W'(RESET_WIDTH);
			load_cnt_q <= '0;
			bie_q      <= '0;
			elem_cnt_q <= '0;
			plane_q    <= '0;
			elem_idx_q <= '0;
			raddr_q    <= '0;
			complete_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				width_q <= cfg_data;
			end
			load_cnt_q <= load_cnt_d;
			bie_q      <= bie_d;
			elem_cnt_q <= elem_cnt_d;
			plane_q    <= plane_d;
			elem_idx_q <= elem_idx_d;
			raddr_q    <= raddr_d;
			complete_q <= complete_d;
			ovf_q      <= ovf_d;
		end
	end

endmodule

FILE: hw/rtl/bps_queue.sv
// Short operation queue between front and back ends.
// Depends on bps_pkg for the entry type and depth.
module bps_queue import bps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_entry_t wr_entry,
	output logic      full,
	input  logic      pop,
	output op_entry_t rd_entry,
	output logic      valid
);

	op_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push, do_pop;

	assign full     = (32'(cnt_q) == QDEPTH);
	assign valid    = (cnt_q != '0);
	assign rd_entry = slot_q[rptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/bps_back.sv
// Back end: owns the byte store, applies queued writes, performs reads
// and holds results in an output register. Depends on bps_pkg.
module bps_back import bps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  op_entry_t q_entry,
	output logic      q_pop,
	output out_t      rsp,
	output logic      empty,
	input  logic      pop
);

	logic [7:0]  store_q [BUFFER_BYTES];
	logic [7:0]  rdata_s1;
	op_entry_t   meta_s1;
	logic        vld_s1;
	out_t        out_q;
	logic        out_vld_q;
	logic        s1_move;
	logic        s1_free;
	logic        take_rd;
	logic        take_wr;

	assign s1_move = vld_s1 && (!out_vld_q || pop);
	assign s1_free = !vld_s1 || s1_move;
	assign take_wr = q_valid && (q_entry.op == OP_WRITE);
	assign take_rd = q_valid && (q_entry.op == OP_READ) && s1_free;
	assign q_pop   = take_wr || take_rd;

	// Store port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (take_wr) begin
			store_q[q_entry.addr] <= q_entry.data;
		end
		if (take_rd) begin
			rdata_s1 <= store_q[q_entry.addr];
			meta_s1  <= q_entry;
		end
		if (s1_move) begin
			out_q.out_byte   <= meta_s1.zero ? 8'd0 : rdata_s1;
			out_q.out_last   <= meta_s1.last;
			out_q.status     <= meta_s1.status;
			out_q.overflowed <= meta_s1.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take_rd) begin
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp   = out_q;
	assign empty = !out_vld_q;

endmodule

FILE: hw/rtl/byte_plane_split_core.sv
// Byte plane split top level: front end, operation queue, back end.
// Depends on bps_pkg, bps_front, bps_queue and bps_back.
//
// Input channel (push/full, payload req): each item loads one byte or fetches
//   the next output byte. The load with final_load set closes the buffer; whole
//   elements of element_width bytes are counted, a trailing partial one dropped.
//   Fetches return the buffer plane by plane: plane j is byte j of every element.
//   A fetch with nothing ready answers status 1 with a zero byte. Loads past
//   capacity are dropped and set a sticky overflow flag.
// Result channel (empty/pop, payload rsp): one result per fetch, none per load.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): element width;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing: one item per cycle while full is low. A fetch passes from the queue
//   into the read stage, which reads the store, and then into the output register
//   where its result shows on rsp. Loads and fetches share the single store port.
// Reset clears the counters, overflow flag and queue and sets the width to 4;
//   the store stays undefined until loaded.
// Stall: while pop is low the output register and read stage hold, then the
//   queue fills and full rises once four items wait in it.
module byte_plane_split_core import bps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_t              req,
	input  logic             push,
	output logic             full,
	output out_t             rsp,
	output logic             empty,
	input  logic             pop,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	op_entry_t fq_entry;
	op_entry_t qb_entry;
	logic      fq_push;
	logic      qb_valid;
	logic      qb_pop;
	logic      accept;

	// Hold incoming items while the queue is full.
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	bps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req       (req),
		.accept    (accept),
		.q_entry   (fq_entry),
		.q_push    (fq_push)
	);

	bps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.wr_entry (fq_entry),
		.full     (full),
		.pop      (qb_pop),
		.rd_entry (qb_entry),
		.valid    (qb_valid)
	);

	bps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (qb_valid),
		.q_entry (qb_entry),
		.q_pop   (qb_pop),
		.rsp     (rsp),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

FILE: hw/rtl/bps_checker.sv
// Port-level checker for byte_plane_split_core, attached by bind.
// Depends on bps_pkg.
module bps_checker import bps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic full,
	input out_t rsp,
	input logic empty,
	input logic pop
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("result or full flag seen during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(rsp))
		else $error("waiting result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status |-> rsp.out_byte == 8'd0 && !rsp.out_last)
		else $error("empty status with nonzero byte or last");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.out_last |-> !rsp.status)
		else $error("last flag on an empty status");

endmodule

bind byte_plane_split_core bps_checker u_chk (.*);

FILE: dv/tb_byte_plane_split_core.sv
// Self-checking testbench for byte_plane_split_core: byte-plane shuffle of a loaded buffer.
// Depends on bps_pkg and the core RTL. It predicts every fetch answer in a shadow model
// and compares each popped result against it.
module tb_byte_plane_split_core;
	import bps_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	in_t              req = '0;
	logic             push = 1'b0;
	logic             full;
	out_t             rsp;
	logic             empty;
	logic             pop = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	byte_plane_split_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.full      (full),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the shuffle state; it advances once per accepted item.
	logic [7:0]       shadow_bytes [BUFFER_BYTES];
	bit               shadow_written [BUFFER_BYTES];
	logic [CFG_W-1:0] width_reg = CFG_W'(RESET_WIDTH);
	int unsigned      load_cnt = 0;
	int unsigned      pos_in_elem = 0;
	int unsigned      elem_cnt = 0;
	int unsigned      plane = 0;
	int unsigned      elem_idx = 0;
	int unsigned      rd_addr = 0;
	bit               buf_done = 1'b0;
	bit               ovf_sticky = 1'b0;

	// Fetch answers predicted but not yet popped, oldest first.
	out_t fetch_answers [$];

	// Run statistics and error tally.
	int unsigned item_total = 0;
	int unsigned load_total = 0;
	int unsigned fetch_total = 0;
	int unsigned plane_bytes = 0;
	int unsigned width_writes = 0;
	int unsigned full_stalls = 0;
	int unsigned mismatch_count = 0;

	// Idling controls shared between the stimulus and the pop driver.
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit hold_request = 1'b0;

	// Clamp the register the way the block does: 0 acts as 1, above MAX_WIDTH saturates.
	function automatic int unsigned width_now();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	// True when the next fetch would return a valid byte from a store entry never loaded.
	function automatic bit reads_unwritten();
		return buf_done && elem_cnt != 0 && plane < width_now() &&
			rd_addr < BUFFER_BYTES && !shadow_written[rd_addr];
	endfunction

	// Plane bytes still owed for the current buffer at the current width.
	function automatic int unsigned bytes_left();
		int unsigned w;
		w = width_now();
		if (!buf_done || elem_cnt == 0 || plane >= w)
			return 0;
		return (w - plane) * elem_cnt - elem_idx;
	endfunction

	// Advance the shadow state by one accepted item; queue the answer of a fetch.
	function automatic void shuffle_predict(in_t item);
		int unsigned w;
		out_t        ans;
		w = width_now();
		if (item.command == CMD_LOAD) begin
			load_total++;
			// A load after a closed buffer opens a fresh one; overflow stays sticky.
			if (buf_done) begin
				load_cnt    = 0;
				pos_in_elem = 0;
				elem_cnt    = 0;
				plane       = 0;
				elem_idx    = 0;
				rd_addr     = 0;
				buf_done    = 1'b0;
			end
			if (load_cnt < BUFFER_BYTES) begin
				shadow_bytes[load_cnt]   = item.data_byte;
				shadow_written[load_cnt] = 1'b1;
				load_cnt++;
				if (pos_in_elem + 1 >= w) begin
					pos_in_elem = 0;
					elem_cnt++;
				end else begin
					pos_in_elem++;
				end
			end else begin
				ovf_sticky = 1'b1;
			end
			// The final flag closes the buffer even when its byte was dropped.
			if (item.final_load) begin
				buf_done = 1'b1;
				plane    = 0;
				elem_idx = 0;
				rd_addr  = 0;
			end
		end else begin
			fetch_total++;
			ans.out_byte   = 8'h00;
			ans.out_last   = 1'b0;
			ans.status     = 1'b1;
			ans.overflowed = ovf_sticky;
			if (buf_done && elem_cnt != 0 && plane < w) begin
				ans.out_byte = (rd_addr < BUFFER_BYTES) ? shadow_bytes[rd_addr] : 8'h00;
				ans.status   = 1'b0;
				plane_bytes++;
				if (elem_idx + 1 >= elem_cnt) begin
					ans.out_last = (plane + 1 >= w);
					plane++;
					elem_idx = 0;
					rd_addr  = plane;
				end else begin
					elem_idx++;
					rd_addr += w;
				end
			end
			fetch_answers.push_back(ans);
		end
	endfunction

	// Offer one item from a falling edge, hold it until accepted, then predict it.
	// Leave push high so back-to-back items stream at full rate.
	task automatic send_item(input in_t item);
		// Never fetch from an entry that was never loaded: open a new buffer instead.
		if (item.command == CMD_FETCH && reads_unwritten()) begin
			item.command    = CMD_LOAD;
			item.final_load = 1'b0;
		end
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req  <= item;
		push <= 1'b1;
		do @(posedge clk); while (full);
		item_total++;
		shuffle_predict(item);
		@(negedge clk);
	endtask

	// Mostly random bytes, with the extremes showing up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic load_byte(input logic [7:0] b, input bit fin);
		in_t item;
		item.command    = CMD_LOAD;
		item.data_byte  = b;
		item.final_load = fin;
		send_item(item);
	endtask

	// Fetch with random junk on the ignored fields.
	task automatic fetch_one();
		in_t item;
		item.command    = CMD_FETCH;
		item.data_byte  = 8'($urandom_range(0, 255));
		item.final_load = 1'($urandom_range(0, 1));
		send_item(item);
	endtask

	// Drop push, wait until every answer has been popped, then let queued loads drain.
	task automatic wait_idle();
		push <= 1'b0;
		while (fetch_answers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write the width register; call only while the block is idle.
	task automatic write_width(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		width_reg = value;
		width_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Load a buffer closed by its last byte, then fetch every plane byte owed plus extra fetches.
	task automatic load_and_drain(input int unsigned n_bytes, input int unsigned extra);
		int unsigned k;
		for (int unsigned i = 0; i < n_bytes; i++)
			load_byte(pick_byte(), i == n_bytes - 1);
		k = bytes_left() + extra;
		repeat (k) fetch_one();
	endtask

	// Empty fetches, a buffer too short for one element, a partial trailing element,
	// and reading past the last plane byte.
	task automatic test_basic_shuffle();
		fetch_one();
		fetch_one();
		load_byte(8'hA5, 1'b1);
		fetch_one();
		load_byte(8'h00, 1'b0);
		load_byte(8'hFF, 1'b0);
		load_byte(8'h01, 1'b0);
		load_byte(8'h80, 1'b0);
		load_byte(8'h7F, 1'b0);
		load_byte(8'hFE, 1'b1);
		repeat (5) fetch_one();
		wait_idle();
	endtask

	// Sweep the register, including 0 and values above the maximum width.
	task automatic test_width_sweep();
		logic [CFG_W-1:0] widths [10];
		int unsigned      w;
		widths = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd17, 5'd31,
			CFG_W'($urandom_range(1, 15))};
		foreach (widths[i]) begin
			write_width(widths[i]);
			w = width_now();
			load_and_drain(w * $urandom_range(1, 3) + $urandom_range(0, w - 1),
				$urandom_range(1, 2));
			wait_idle();
		end
	endtask

	// Change the width while a closed buffer is partly read back.
	task automatic test_width_midway();
		write_width(5'd4);
		for (int unsigned i = 0; i < 16; i++)
			load_byte(pick_byte(), i == 15);
		repeat (3) fetch_one();
		wait_idle();
		write_width(5'd2);
		repeat (10) fetch_one();
		wait_idle();
		write_width(5'd8);
		for (int unsigned i = 0; i < 12; i++)
			load_byte(pick_byte(), i == 11);
		repeat (2) fetch_one();
		wait_idle();
		write_width(5'd1);
		repeat (12) fetch_one();
		wait_idle();
	endtask

	// Random buffers at random widths; mostly well-formed, some broken on purpose.
	task automatic test_random_traffic();
		int unsigned start_count;
		int unsigned n_bytes;
		int unsigned n_fetch;
		start_count = item_total;
		while (item_total - start_count < 900) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				if ($urandom_range(0, 3) == 0)
					write_width(CFG_W'($urandom_range(0, 31)));
				else
					write_width(CFG_W'($urandom_range(1, 16)));
			end
			// Leave some stretches with no idling at all.
			tx_idle_en = ($urandom_range(0, 4) != 0);
			rx_idle_en = ($urandom_range(0, 4) != 0);
			n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
				: $urandom_range(1, 24);
			for (int unsigned i = 0; i < n_bytes; i++) begin
				// Sprinkle fetches into the load stream; they find nothing ready unless a closed buffer still has bytes owed.
				if ($urandom_range(0, 9) == 0)
					fetch_one();
				// Now and then drop the final flag or close the buffer early.
				if (i == n_bytes - 1)
					load_byte(pick_byte(), $urandom_range(0, 19) != 0);
				else
					load_byte(pick_byte(), $urandom_range(0, 29) == 0);
			end
			n_fetch = bytes_left() + $urandom_range(0, 2);
			// Abandon some read-backs halfway so the next load cuts in.
			if ($urandom_range(0, 7) == 0)
				n_fetch = $urandom_range(0, n_fetch);
			repeat (n_fetch) fetch_one();
		end
		wait_idle();
	endtask

	// Hold pop off for a long stretch while fetches keep coming, so full must rise.
	task automatic test_result_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_width(5'd4);
		for (int unsigned i = 0; i < 32; i++)
			load_byte(pick_byte(), i == 31);
		hold_request = 1'b1;
		repeat (36) fetch_one();
		wait_idle();
	endtask

	// Fill the store past capacity with the final flag on a dropped byte; no idling here.
	task automatic test_overflow();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_width(5'd16);
		for (int unsigned i = 0; i < BUFFER_BYTES + 4; i++)
			load_byte(8'($urandom_range(0, 255)), i == BUFFER_BYTES + 3);
		repeat (40) fetch_one();
		wait_idle();
		// The overflow flag survives into the next buffer.
		write_width(5'd1);
		load_and_drain(5, 1);
		wait_idle();
	endtask

	// Pop driver: random stalls, plus one long hold on request.
	initial begin : pop_drive
		int unsigned hold_left;
		int unsigned burst_left;
		hold_left  = 0;
		burst_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 80;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				pop <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 11) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Compare each popped result with the oldest predicted answer.
	always @(posedge clk) begin : result_check
		out_t want;
		out_t got;
		if (arst_n && push && full)
			full_stalls++;
		if (arst_n && pop && !empty) begin
			got = rsp;
			if (fetch_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: byte %h last %b status %b ovf %b",
						got.out_byte, got.out_last, got.status, got.overflowed);
			end else begin
				want = fetch_answers.pop_front();
				if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
						got.status !== want.status || got.overflowed !== want.overflowed) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"result mismatch: byte %h/%h last %b/%b status %b/%b ",
							"ovf %b/%b (got/expected)"},
							got.out_byte, want.out_byte, got.out_last, want.out_last,
							got.status, want.status, got.overflowed, want.overflowed);
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		#8000000;
		$display("[byte_plane_split_core] ERROR");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_basic_shuffle();
		test_width_sweep();
		test_width_midway();
		test_random_traffic();
		test_result_backpressure();
		test_overflow();
		$display("ran %0d items: %0d loads, %0d fetches, %0d plane bytes, %0d width writes",
			item_total, load_total, fetch_total, plane_bytes, width_writes);
		$display("input held off by full for %0d cycles; store overflow and width clamps hit",
			full_stalls);
		if (mismatch_count == 0 && fetch_answers.size() == 0)
			$display("[byte_plane_split_core] OK");
		else
			$display("[byte_plane_split_core] ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_front.sv
hw/rtl/bps_queue.sv
hw/rtl/bps_back.sv
hw/rtl/byte_plane_split_core.sv
hw/rtl/bps_checker.sv
dv/tb_byte_plane_split_core.sv
